/* src/rtpo_pkg.sv */
// package: sizes, widths and sequencer states of the rank-to-pseudo-observation block
package rtpo_pkg;

    localparam int MAX_SAMPLES   = 64;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int FRACTION_BITS = 16;

    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int COUNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int DIV_W     = COUNT_W + 1;
    localparam int DIV_CNT_W = $clog2(FRACTION_BITS);
    localparam int RANK_W    = 7;

    typedef enum logic [2:0] {
        S_LOAD,
        S_KEY,
        S_SCAN,
        S_DIV,
        S_EMIT
    } rtpo_state_t;

endpackage

/* src/rank_to_pseudo_observation.sv */
// Rank transform of one column of signed samples into pseudo-observations.
// Samples are taken one per transfer and written to an on-chip store of
// 64 entries until the transfer marked last_sample; samples beyond 64 are
// dropped and flagged in overflow. No input is taken while the column is
// being ranked. For each stored sample, in arrival order, the sample's key
// is read, then every stored sample is scanned through one memory read port
// (one compare a cycle), and the rank is divided by n+1 in a bit-serial
// divider, one quotient bit a cycle. Ties rank by arrival order, earlier
// sample lower. A finished result waits in an output register while the
// next one is computed, and after the last result the next column can load
// at once. The store needs no clearing after reset.
module rank_to_pseudo_observation (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [rtpo_pkg::SAMPLE_WIDTH-1:0]  sample_value,
    input  logic                                  last_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rtpo_pkg::RANK_W-1:0]           rank_position,
    output logic [rtpo_pkg::FRACTION_BITS-1:0]    pseudo_observation,
    output logic                                  last_of_run,
    output logic                                  overflow
);

    localparam int AW  = rtpo_pkg::ADDR_W;
    localparam int CW  = rtpo_pkg::COUNT_W;
    localparam int DW  = rtpo_pkg::DIV_W;
    localparam int SW  = rtpo_pkg::SAMPLE_WIDTH;
    localparam int FB  = rtpo_pkg::FRACTION_BITS;
    localparam int QW  = rtpo_pkg::DIV_CNT_W;
    localparam int RW  = rtpo_pkg::RANK_W;
    localparam int MAX = rtpo_pkg::MAX_SAMPLES;

    // sample store, keys in offset-binary form
    logic [SW-1:0] store_mem [MAX];
    logic [SW-1:0] key_i_reg;
    logic [SW-1:0] key_j_reg;

    rtpo_pkg::rtpo_state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] cmp_idx_reg;
    logic          cmp_valid_reg;
    logic [CW-1:0] rank_reg;
    logic [DW-1:0] rem_reg;
    logic [FB-1:0] quo_reg;
    logic [QW-1:0] div_cnt_reg;

    logic          out_valid_reg;
    logic [RW-1:0] out_rank_reg;
    logic [FB-1:0] out_frac_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;

    logic          in_xfer;
    logic          store_full;
    logic          scan_done;
    logic          div_done;
    logic          out_free;
    logic          last_item;
    logic          key_less;
    logic [DW-1:0] divisor;
    logic [DW-1:0] rem_shift;
    logic          rem_ge;
    logic [SW-1:0] in_key;

    // control decodes
    always_comb
    begin
        in_ready   = (state_reg == rtpo_pkg::S_LOAD);
        in_xfer    = in_valid && in_ready;
        store_full = (count_reg == CW'(MAX));
        scan_done  = !cmp_valid_reg && (j_reg == count_reg);
        div_done   = (div_cnt_reg == QW'(FB - 1));
        out_free   = !out_valid_reg || out_ready;
        last_item  = ({1'b0, i_reg} + DW'(1)) == {1'b0, count_reg};
        in_key     = sample_value ^ {1'b1, {(SW-1){1'b0}}};
        key_less   = (key_j_reg < key_i_reg)
                     || ((key_j_reg == key_i_reg) && (cmp_idx_reg < i_reg));
        divisor    = {1'b0, count_reg} + DW'(1);
        rem_shift  = {rem_reg[DW-2:0], 1'b0};
        rem_ge     = (rem_shift >= divisor);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtpo_pkg::S_LOAD:
            begin
                if (in_xfer && last_sample)
                    state_next = rtpo_pkg::S_KEY;
            end
            rtpo_pkg::S_KEY:
            begin
                state_next = rtpo_pkg::S_SCAN;
            end
            rtpo_pkg::S_SCAN:
            begin
                if (scan_done)
                    state_next = rtpo_pkg::S_DIV;
            end
            rtpo_pkg::S_DIV:
            begin
                if (div_done)
                    state_next = rtpo_pkg::S_EMIT;
            end
            rtpo_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = last_item ? rtpo_pkg::S_LOAD : rtpo_pkg::S_KEY;
            end
            default:
            begin
                state_next = rtpo_pkg::S_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rtpo_pkg::S_LOAD;
        else
            state_reg <= state_next;
    end

    // store write on sample transfer, two registered read ports
    always_ff @(posedge clk)
    begin
        if (in_xfer && !store_full)
            store_mem[count_reg[AW-1:0]] <= in_key;
        key_i_reg <= store_mem[i_reg[AW-1:0]];
        key_j_reg <= store_mem[j_reg[AW-1:0]];
    end

    // column control: count, overflow, indexes, rank scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                rtpo_pkg::S_LOAD:
                begin
                    if (in_xfer)
                    begin
                        if (store_full)
                            ovf_reg <= 1'b1;
                        else
                            count_reg <= count_reg + CW'(1);
                    end
                    i_reg <= '0;
                end
                rtpo_pkg::S_KEY:
                begin
                    j_reg         <= '0;
                    cmp_valid_reg <= 1'b0;
                end
                rtpo_pkg::S_SCAN:
                begin
                    if (j_reg != count_reg)
                    begin
                        cmp_idx_reg   <= j_reg;
                        cmp_valid_reg <= 1'b1;
                        j_reg         <= j_reg + CW'(1);
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b0;
                    end
                    div_cnt_reg <= '0;
                end
                rtpo_pkg::S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + QW'(1);
                end
                rtpo_pkg::S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (last_item)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                        else
                        begin
                            i_reg <= i_reg + CW'(1);
                        end
                    end
                end
                default:
                begin
                    cmp_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // rank accumulation and restoring divider, one quotient bit a cycle
    // the last scan cycle has no compare pending, so rem_reg ends on the final rank
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rtpo_pkg::S_KEY:
            begin
                rank_reg <= CW'(1);
            end
            rtpo_pkg::S_SCAN:
            begin
                if (cmp_valid_reg && key_less)
                    rank_reg <= rank_reg + CW'(1);
                rem_reg <= {1'b0, rank_reg};
                quo_reg <= '0;
            end
            rtpo_pkg::S_DIV:
            begin
                rem_reg <= rem_ge ? (rem_shift - divisor) : rem_shift;
                quo_reg <= {quo_reg[FB-2:0], rem_ge};
            end
            default:
            begin
                rank_reg <= rank_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == rtpo_pkg::S_EMIT) && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == rtpo_pkg::S_EMIT) && out_free)
        begin
            out_rank_reg <= RW'(rank_reg);
            out_frac_reg <= quo_reg;
            out_last_reg <= last_item;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign rank_position      = out_rank_reg;
    assign pseudo_observation = out_frac_reg;
    assign last_of_run        = out_last_reg;
    assign overflow           = out_ovf_reg;

endmodule
